### rtl/core/snpq_pkg.sv
// Shared constants and control types for the noise-shaped PWM quantizer.
package snpq_pkg;

    localparam int unsigned SAMPLE_W = 32;
    localparam int unsigned DUTY_W   = 16;
    localparam int unsigned SUM_W    = 36;   // sample + 2*e1 - e2 + dither, with headroom
    localparam int unsigned DRAW_W   = 21;   // widest dither draw (11-bit minimum resolution)
    localparam int unsigned Q_W      = 14;   // clamped quantizer level, signed
    localparam int unsigned RES_W    = 4;
    localparam int unsigned SHIFT_W  = 5;
    localparam int unsigned OP_W     = 2;

    localparam logic [31:0] LCG_MUL = 32'd1664525;
    localparam logic [31:0] LCG_ADD = 32'd1013904223;
    localparam logic [31:0] SEED_L  = 32'h12345678;
    localparam logic [31:0] SEED_R  = 32'h9e3779b9;

    localparam logic [RES_W-1:0] RES_MIN   = 4'd11;
    localparam logic [RES_W-1:0] RES_MAX   = 4'd13;
    localparam logic [RES_W-1:0] RES_RESET = 4'd12;

    localparam logic [OP_W-1:0] OP_STEREO = 2'd0;
    localparam logic [OP_W-1:0] OP_MONO   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic REG_RES_BITS    = 1'b0;
    localparam logic REG_PASSTHROUGH = 1'b1;

    typedef struct packed {
        logic latch;        // capture the incoming transaction
        logic clear;        // return shaper state to reset values
        logic draw1;        // first LCG step, minuend draw
        logic draw2;        // second LCG step, subtrahend draw
        logic sum;          // form sample + feedback + dither
        logic commit;       // quantize, store error history
        logic load_shaped;  // load duty values into the output register
        logic load_raw;     // load raw upper sample bits into the output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic passthrough;
    } ctrl_status_t;

    typedef struct packed {
        logic clear;
        logic draw1;
        logic draw2;
        logic sum;
        logic commit;
    } lane_cmd_t;

endpackage

### rtl/core/snpq_ctrl.sv
// Sequencer for the quantizer: accepts transactions and steps the datapath.
module snpq_ctrl import snpq_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [OP_W-1:0]  s_op,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  ctrl_status_t     status,
    output ctrl_cmd_t        cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DRAW1 = 3'd1;
    localparam logic [2:0] ST_DRAW2 = 3'd2;
    localparam logic [2:0] ST_SUM   = 3'd3;
    localparam logic [2:0] ST_QUANT = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch = 1'b1;
                    case (s_op)
                        OP_CLEAR: cmd.clear = 1'b1;
                        OP_STEREO, OP_MONO: begin
                            state_next = status.passthrough ? ST_EMIT : ST_DRAW1;
                        end
                        default: ;  // unused code: drop
                    endcase
                end
            end
            ST_DRAW1: begin
                cmd.draw1  = 1'b1;
                state_next = ST_DRAW2;
            end
            ST_DRAW2: begin
                cmd.draw2  = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_QUANT;
            end
            ST_QUANT: begin
                // hold the shaper state until the output register has room
                if (out_free) begin
                    cmd.commit      = 1'b1;
                    cmd.load_shaped = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.load_raw = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.load_shaped || cmd.load_raw) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

### rtl/core/snpq_lane.sv
// One channel of the shaper: LCG dither, error feedback, rounding and clamp.
module snpq_lane import snpq_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [31:0]         seed_init,
    input  lane_cmd_t           cmd,
    input  logic                enable,
    input  logic [SAMPLE_W-1:0] x,
    input  logic [SHIFT_W-1:0]  shift,
    input  logic [DRAW_W-1:0]   mask,
    input  logic [Q_W-1:0]      half,
    output logic [DUTY_W-1:0]   duty
);

    logic [31:0]         seed_reg, seed_next;
    logic [31:0]         prev_reg, prev_next;
    logic [31:0]         older_reg, older_next;
    logic [DRAW_W-1:0]   a_reg, b_reg;
    logic [SUM_W-1:0]    y_reg;
    logic [31:0]         lcg;
    logic [SUM_W-1:0]    y_sum;
    logic [SUM_W-1:0]    t;
    logic signed [SUM_W-1:0] q_full;
    logic signed [SUM_W-1:0] q_hi, q_lo;
    logic [Q_W-1:0]      q;
    logic [31:0]         err;

    assign lcg = 32'(seed_reg * LCG_MUL) + LCG_ADD;

    assign y_sum = {{4{x[31]}}, x}
                 + {{3{prev_reg[31]}}, prev_reg, 1'b0}
                 - {{4{older_reg[31]}}, older_reg}
                 + {{(SUM_W-DRAW_W){1'b0}}, a_reg}
                 - {{(SUM_W-DRAW_W){1'b0}}, b_reg};

    // round half up: add half a step, then floor by arithmetic shift
    assign t      = y_reg + (SUM_W'(1) << (shift - SHIFT_W'(1)));
    assign q_full = $signed(t) >>> shift;
    assign q_hi   = $signed({{(SUM_W-Q_W){1'b0}}, half}) - SUM_W'(1);
    assign q_lo   = -$signed({{(SUM_W-Q_W){1'b0}}, half});

    always_comb begin
        if (q_full > q_hi) begin
            q = Q_W'(q_hi);
        end else if (q_full < q_lo) begin
            q = Q_W'(q_lo);
        end else begin
            q = q_full[Q_W-1:0];
        end
    end

    assign err  = y_reg[31:0] - ({{(32-Q_W){q[Q_W-1]}}, q} << shift);
    assign duty = {{(DUTY_W-Q_W){q[Q_W-1]}}, q} + {{(DUTY_W-Q_W){1'b0}}, half};

    always_comb begin
        seed_next  = seed_reg;
        prev_next  = prev_reg;
        older_next = older_reg;
        if (cmd.clear) begin
            seed_next  = seed_init;
            prev_next  = '0;
            older_next = '0;
        end else if (enable) begin
            if (cmd.draw1 || cmd.draw2) begin
                seed_next = lcg;
            end
            if (cmd.commit) begin
                older_next = prev_reg;
                prev_next  = err;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg  <= seed_init;
            prev_reg  <= '0;
            older_reg <= '0;
        end else begin
            seed_reg  <= seed_next;
            prev_reg  <= prev_next;
            older_reg <= older_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.draw1) begin
            a_reg <= lcg[DRAW_W-1:0] & mask;
        end
        if (cmd.draw2) begin
            b_reg <= lcg[DRAW_W-1:0] & mask;
        end
        if (cmd.sum) begin
            y_reg <= y_sum;
        end
    end

endmodule

### rtl/core/snpq_datapath.sv
// Datapath: configuration registers, sample capture, two shaper lanes, output register.
module snpq_datapath import snpq_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic                cfg_addr,
    input  logic [RES_W-1:0]    cfg_wdata,
    input  logic [OP_W-1:0]     in_op,
    input  logic [SAMPLE_W-1:0] in_left,
    input  logic [SAMPLE_W-1:0] in_right,
    input  ctrl_cmd_t           cmd,
    output ctrl_status_t        status,
    output logic [DUTY_W-1:0]   chan_a_value,
    output logic [DUTY_W-1:0]   chan_b_value
);

    logic [RES_W-1:0]    res_bits_reg;
    logic                pass_reg;
    logic                stereo_reg;
    logic [SAMPLE_W-1:0] left_reg, right_reg;
    logic [DUTY_W-1:0]   chan_a_reg, chan_b_reg;
    logic [RES_W-1:0]    bits_eff;
    logic [SHIFT_W-1:0]  shift;
    logic [DRAW_W:0]     mask_full;
    logic [DRAW_W-1:0]   mask;
    logic [Q_W-1:0]      half;
    lane_cmd_t           lane_cmd;
    logic [DUTY_W-1:0]   duty_l, duty_r;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_bits_reg <= RES_RESET;
            pass_reg     <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_RES_BITS:    res_bits_reg <= cfg_wdata;
                REG_PASSTHROUGH: pass_reg     <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign status.passthrough = pass_reg;

    always_comb begin
        if (res_bits_reg < RES_MIN) begin
            bits_eff = RES_MIN;
        end else if (res_bits_reg > RES_MAX) begin
            bits_eff = RES_MAX;
        end else begin
            bits_eff = res_bits_reg;
        end
    end

    assign shift     = SHIFT_W'(6'd32 - {2'b00, bits_eff});
    assign mask_full = ((DRAW_W+1)'(1) << shift) - (DRAW_W+1)'(1);
    assign mask      = mask_full[DRAW_W-1:0];
    assign half      = Q_W'(1) << (bits_eff - RES_W'(1));

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            stereo_reg <= (in_op == OP_STEREO);
            left_reg   <= in_left;
            right_reg  <= in_right;
        end
    end

    assign lane_cmd.clear  = cmd.clear;
    assign lane_cmd.draw1  = cmd.draw1;
    assign lane_cmd.draw2  = cmd.draw2;
    assign lane_cmd.sum    = cmd.sum;
    assign lane_cmd.commit = cmd.commit;

    snpq_lane u_lane_left (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .seed_init (SEED_L),
        .cmd       (lane_cmd),
        .enable    (1'b1),
        .x         (left_reg),
        .shift     (shift),
        .mask      (mask),
        .half      (half),
        .duty      (duty_l)
    );

    // right lane advances only on stereo frames
    snpq_lane u_lane_right (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .seed_init (SEED_R),
        .cmd       (lane_cmd),
        .enable    (stereo_reg),
        .x         (right_reg),
        .shift     (shift),
        .mask      (mask),
        .half      (half),
        .duty      (duty_r)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load_shaped) begin
            chan_a_reg <= stereo_reg ? duty_r : duty_l;
            chan_b_reg <= duty_l;
        end else if (cmd.load_raw) begin
            chan_a_reg <= left_reg[31:16];
            chan_b_reg <= stereo_reg ? right_reg[31:16] : left_reg[31:16];
        end
    end

    assign chan_a_value = chan_a_reg;
    assign chan_b_value = chan_b_reg;

endmodule

### rtl/core/stereo_noise_shaped_pwm_quantizer.sv
// Top level of the stereo noise-shaped PWM quantizer.
// Outside passthrough, each stereo or mono frame is shaped with second-order
// error feedback and TPDF dither, rounded to the programmed PWM resolution
// (11 to 13 bits, clamped) and returned as offset-binary duty values: channel A
// carries right (or mono), channel B left (or mono); passthrough returns the raw
// upper sample bits, channel A left, channel B right (or mono). Both channels run
// in parallel lanes; a shaped frame passes capture, two chained LCG steps, the
// feedback sum and the quantize step, which waits for output register room.
// The output register lets a new frame in while the previous result still waits.
// Configuration writes take effect at once and do not reset the shaper.
module stereo_noise_shaped_pwm_quantizer import snpq_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [3:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // left_sample [31:0], right_sample [63:32]
    input  logic [1:0]  s_tuser,   // op [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // chan_a_value [15:0], chan_b_value [31:16]
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    snpq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    snpq_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .in_op        (s_tuser),
        .in_left      (s_tdata[31:0]),
        .in_right     (s_tdata[63:32]),
        .cmd          (cmd),
        .status       (status),
        .chan_a_value (m_tdata[15:0]),
        .chan_b_value (m_tdata[31:16])
    );

endmodule
